/* rtl/core/ftb_pkg.sv */
// Package for the float texel to BGRA8 converter.
// Holds the request/result payload structs, the format codes and the pipeline structs.
// No dependencies.
package ftb_pkg;

    typedef enum logic [2:0] {
        FMT_BGRA8  = 3'd0,
        FMT_BGRX8  = 3'd1,
        FMT_RGBA_F32 = 3'd2,
        FMT_RGBA_F16 = 3'd3,
        FMT_R_F32  = 3'd4,
        FMT_RG_F16 = 3'd5
    } fmt_t;

    localparam int NUM_LANES = 4;
    localparam int LANE_R = 0;
    localparam int LANE_G = 1;
    localparam int LANE_B = 2;
    localparam int LANE_A = 3;

    typedef struct packed {
        logic [31:0] chan_red;
        logic [31:0] chan_green;
        logic [31:0] chan_blue;
        logic [31:0] chan_alpha;
        logic        pixel_last;
    } texel_t;

    typedef struct packed {
        logic [31:0] pixel_word;
        logic        has_alpha;
        logic        out_last;
    } result_t;

    // sideband that travels alongside the lanes
    typedef struct packed {
        logic        valid;
        fmt_t        fmt;
        logic        last;
        logic [31:0] raw;
    } meta_t;

    // lane stage one: product and classification
    typedef struct packed {
        logic        force_zero;
        logic        force_sat;
        logic [31:0] prod;
        logic [3:0]  e_off;
    } lane_s1_t;

endpackage

/* rtl/core/ftb_lane.sv */
// One channel lane: half/float32 decode, multiply by 255, RNE to 24 bits, truncate, clamp.
// Two register stages. Depends on ftb_pkg.
module ftb_lane (
    input  logic        clk,
    input  logic [31:0] bits,
    input  logic        is_half,
    output logic [7:0]  chan_byte
);
    import ftb_pkg::*;

    logic        sign;
    logic        special;
    logic        is_zero;
    logic        mant_nz;
    logic [7:0]  expo;
    logic [23:0] sig;
    logic [7:0]  e_diff;
    lane_s1_t    s1_next;
    lane_s1_t    s1_reg;

    logic [23:0] q;
    logic        guard;
    logic        sticky;
    logic        round_up;
    logic [24:0] q_rnd;
    logic [4:0]  sh;
    logic [24:0] shifted;
    logic [7:0]  byte_next;
    logic [7:0]  byte_reg;

    always_comb
    begin
        if (is_half)
        begin
            sign    = bits[15];
            special = (bits[14:10] == 5'h1F);
            is_zero = (bits[14:10] == 5'h00);
            mant_nz = |bits[9:0];
            expo    = {3'b000, bits[14:10]} + 8'd112;
            sig     = {1'b1, bits[9:0], 13'b0};
        end
        else
        begin
            sign    = bits[31];
            special = (bits[30:23] == 8'hFF);
            is_zero = (bits[30:23] == 8'h00);
            mant_nz = |bits[22:0];
            expo    = bits[30:23];
            sig     = {1'b1, bits[22:0]};
        end
        e_diff = expo - 8'd119;

        s1_next.force_zero = sign || (special && mant_nz) || is_zero ||
                             (!special && (expo < 8'd119));
        s1_next.force_sat  = !special ? (expo >= 8'd135) : !mant_nz;
        s1_next.prod       = {sig, 8'b0} - {8'b0, sig};
        s1_next.e_off      = e_diff[3:0];
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    always_comb
    begin
        if (s1_reg.prod[31])
        begin
            q      = s1_reg.prod[31:8];
            guard  = s1_reg.prod[7];
            sticky = |s1_reg.prod[6:0];
            sh     = 5'd23 - {1'b0, s1_reg.e_off};
        end
        else
        begin
            q      = s1_reg.prod[30:7];
            guard  = s1_reg.prod[6];
            sticky = |s1_reg.prod[5:0];
            sh     = 5'd24 - {1'b0, s1_reg.e_off};
        end
        round_up = guard && (sticky || q[0]);
        q_rnd    = {1'b0, q} + {24'b0, round_up};
        shifted  = q_rnd >> sh;

        if (s1_reg.force_zero)
            byte_next = 8'h00;
        else if (s1_reg.force_sat || (shifted > 25'd255))
            byte_next = 8'hFF;
        else
            byte_next = shifted[7:0];
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign chan_byte = byte_reg;

endmodule

/* rtl/core/ftb_merge.sv */
// Merge stage: packs lane bytes or the raw word into the A8R8G8B8 result per format.
// Registered output with a one-cycle strobe. Depends on ftb_pkg.
module ftb_merge (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ftb_pkg::meta_t                       meta,
    input  logic [ftb_pkg::NUM_LANES-1:0][7:0]   lane_bytes,
    output logic                                 done,
    output ftb_pkg::result_t                     result
);
    import ftb_pkg::*;

    logic    done_reg;
    logic    done_next;
    result_t result_reg;
    result_t result_next;

    always_comb
    begin
        done_next              = meta.valid;
        result_next.out_last   = meta.last;
        result_next.pixel_word = 32'h0;
        result_next.has_alpha  = 1'b0;
        case (meta.fmt)
            FMT_BGRA8:
            begin
                result_next.pixel_word = meta.raw;
                result_next.has_alpha  = 1'b1;
            end
            FMT_BGRX8:
            begin
                result_next.pixel_word = meta.raw;
            end
            FMT_RGBA_F32, FMT_RGBA_F16:
            begin
                result_next.pixel_word = {lane_bytes[LANE_A], lane_bytes[LANE_R],
                                          lane_bytes[LANE_G], lane_bytes[LANE_B]};
                result_next.has_alpha  = 1'b1;
            end
            FMT_R_F32:
            begin
                result_next.pixel_word = {8'hFF, lane_bytes[LANE_R], 16'h0};
            end
            FMT_RG_F16:
            begin
                result_next.pixel_word = {8'hFF, lane_bytes[LANE_R],
                                          lane_bytes[LANE_G], 8'h00};
            end
            default:
            begin
                result_next.pixel_word = 32'h0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/core/float_texel_to_bgra8_converter.sv */
// Float texel to BGRA8 converter, top level.
// A request passes meta1_reg, meta2_reg and merge done_reg; one request per cycle.
// Throughput is set by the four lanes, each a two-stage multiply/round pipeline.
// busy is held low; the receiver cannot stall, so results are never held back.
// Reset (rst_n, async low) clears the pipeline valids and sets fmt_reg to BGRA8.
// Depends on ftb_pkg, ftb_lane, ftb_merge.
module float_texel_to_bgra8_converter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ftb_pkg::texel_t   texel,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_wdata,
    output logic              done,
    output ftb_pkg::result_t  result
);
    import ftb_pkg::*;

    fmt_t  fmt_reg;
    fmt_t  fmt_next;
    meta_t meta1_reg;
    meta_t meta1_next;
    meta_t meta2_reg;
    logic  is_half;
    logic  accept;
    logic [NUM_LANES-1:0][7:0]  lane_bytes;
    logic [NUM_LANES-1:0][31:0] lane_bits;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign fmt_next = cfg_we ? fmt_t'(cfg_wdata) : fmt_reg;

    always_comb
    begin
        meta1_next.valid = accept;
        meta1_next.fmt   = fmt_reg;
        meta1_next.last  = texel.pixel_last;
        meta1_next.raw   = texel.chan_red;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= FMT_BGRA8;
            meta1_reg <= '0;
            meta2_reg <= '0;
        end
        else
        begin
            fmt_reg   <= fmt_next;
            meta1_reg <= meta1_next;
            meta2_reg <= meta1_reg;
        end
    end

    assign is_half = (fmt_reg == FMT_RGBA_F16) || (fmt_reg == FMT_RG_F16);

    assign lane_bits[LANE_R] = texel.chan_red;
    assign lane_bits[LANE_G] = texel.chan_green;
    assign lane_bits[LANE_B] = texel.chan_blue;
    assign lane_bits[LANE_A] = texel.chan_alpha;

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        ftb_lane u_lane (
            .clk       (clk),
            .bits      (lane_bits[i]),
            .is_half   (is_half),
            .chan_byte (lane_bytes[i])
        );
    end

    ftb_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .meta       (meta2_reg),
        .lane_bytes (lane_bytes),
        .done       (done),
        .result     (result)
    );

    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##2 done)
        else $error("request did not produce a result after three cycles");

    a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(meta1_reg.valid, 2))
        else $error("result without a matching request");

    a_alpha_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.has_alpha == ((meta2_reg.fmt == FMT_BGRA8) ? 1'b1 :
            $past((meta2_reg.fmt == FMT_BGRA8) || (meta2_reg.fmt == FMT_RGBA_F32) ||
                  (meta2_reg.fmt == FMT_RGBA_F16), 1))))
        else $error("has_alpha disagrees with the request format");

    a_last_copy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.out_last == $past(meta2_reg.last, 1)))
        else $error("out_last not carried with its request");

endmodule

/* sim/tb_float_texel_to_bgra8_converter.sv */
// Testbench for float_texel_to_bgra8_converter: directed and random texels in every source format.
// Each pixel word is predicted here and checked in order against the done strobe.
// Depends on ftb_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_float_texel_to_bgra8_converter;
    import ftb_pkg::*;

    localparam logic [2:0] FMT_RSVD_6 = 3'd6;
    localparam logic [2:0] FMT_RSVD_7 = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned RANDOM_PHASES = 24;
    localparam int unsigned TEXELS_PER_PHASE = 48;

    typedef struct {
        bit          is_fmt_write;
        logic [2:0]  fmt;
        texel_t      tx;
        int unsigned gap;
    } work_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    texel_t     texel = '0;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_wdata = 3'd0;
    logic       done;
    result_t    result;

    work_t       pending_work[$];
    result_t     expected_pixels[$];
    logic [2:0]  fmt_shadow = FMT_BGRA8;
    int unsigned idle_wait = 0;
    int unsigned texels_sent = 0;
    int unsigned format_writes = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    float_texel_to_bgra8_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .texel     (texel),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // sig * 2^sh times 255, rounded to float32 (RNE), truncated, clamped to 0..255
    function automatic logic [7:0] scale255(input logic [24:0] sig, input int sh);
        logic [63:0] prod;
        logic [63:0] kept;
        logic [63:0] rest;
        logic [63:0] halfway;
        int nbits;
        int drop;
        int shift;
        nbits = 0;
        shift = sh;
        if (sig == '0)
            return 8'd0;
        if (shift >= 0)
            return 8'd255;
        prod = 64'(sig) * 64'd255;
        for (int i = 0; i < 64; i++)
        begin
            if (prod[i])
                nbits = i + 1;
        end
        drop = (nbits > 24) ? nbits - 24 : 0;
        kept = prod;
        if (drop > 0)
        begin
            kept = prod >> drop;
            rest = prod & ((64'd1 << drop) - 64'd1);
            halfway = 64'd1 << (drop - 1);
            if (rest > halfway || (rest == halfway && kept[0]))
                kept = kept + 64'd1;
        end
        shift = shift + drop;
        if (shift >= 0)
        begin
            if (shift > 8)
                return 8'd255;
            kept = kept << shift;
        end
        else
        begin
            if (-shift >= 64)
                return 8'd0;
            kept = kept >> (-shift);
        end
        return (kept > 64'd255) ? 8'd255 : kept[7:0];
    endfunction

    function automatic logic [7:0] f32_to_u8(input logic [31:0] bits);
        logic [7:0] e;
        e = bits[30:23];
        if (e == 8'hFF)
            return (bits[22:0] != '0 || bits[31]) ? 8'd0 : 8'd255;
        if (bits[31])
            return 8'd0;
        if (e == 8'd0)
            return scale255({2'b00, bits[22:0]}, -149);
        return scale255({2'b01, bits[22:0]}, int'(e) - 150);
    endfunction

    function automatic logic [7:0] f16_to_u8(input logic [15:0] bits);
        logic [4:0] e;
        e = bits[14:10];
        if (e == 5'h1F)
            return (bits[9:0] != '0 || bits[15]) ? 8'd0 : 8'd255;
        if (bits[15])
            return 8'd0;
        if (e == 5'd0)
            return scale255({15'd0, bits[9:0]}, -24);
        return scale255({14'd0, 1'b1, bits[9:0]}, int'(e) - 25);
    endfunction

    function automatic result_t predict_pixel(input texel_t t, input logic [2:0] f);
        result_t r;
        r.pixel_word = '0;
        r.has_alpha = 1'b0;
        r.out_last = t.pixel_last;
        case (f)
            FMT_BGRA8:
            begin
                r.pixel_word = t.chan_red;
                r.has_alpha = 1'b1;
            end
            FMT_BGRX8:
                r.pixel_word = t.chan_red;
            FMT_RGBA_F32:
            begin
                r.pixel_word = {f32_to_u8(t.chan_alpha), f32_to_u8(t.chan_red),
                                f32_to_u8(t.chan_green), f32_to_u8(t.chan_blue)};
                r.has_alpha = 1'b1;
            end
            FMT_RGBA_F16:
            begin
                r.pixel_word = {f16_to_u8(t.chan_alpha[15:0]), f16_to_u8(t.chan_red[15:0]),
                                f16_to_u8(t.chan_green[15:0]), f16_to_u8(t.chan_blue[15:0])};
                r.has_alpha = 1'b1;
            end
            FMT_R_F32:
                r.pixel_word = {8'hFF, f32_to_u8(t.chan_red), 16'h0000};
            FMT_RG_F16:
                r.pixel_word = {8'hFF, f16_to_u8(t.chan_red[15:0]),
                                f16_to_u8(t.chan_green[15:0]), 8'h00};
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_f32();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0: ;
            1: v[30:23] = 8'd0;
            2: v[30:23] = 8'hFF;
            3: v = {1'b0, 8'd127, 23'd0};
            default:
            begin
                v[30:23] = 8'($urandom_range(115, 128));
                v[31] = ($urandom_range(0, 7) == 0);
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_f16();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0: ;
            1: v[14:10] = 5'd0;
            2: v[14:10] = 5'h1F;
            3: v[15:0] = 16'h3C00;
            default:
            begin
                v[14:10] = 5'($urandom_range(6, 15));
                v[15] = ($urandom_range(0, 7) == 0);
            end
        endcase
        return v;
    endfunction

    task automatic add_texel(input logic [31:0] r, input logic [31:0] g, input logic [31:0] b,
                             input logic [31:0] a, input logic last, input int unsigned gap);
        work_t w;
        w.is_fmt_write = 1'b0;
        w.fmt = '0;
        w.tx = texel_t'{r, g, b, a, last};
        w.gap = gap;
        pending_work.push_back(w);
    endtask

    task automatic add_format(input logic [2:0] f);
        work_t w;
        w.is_fmt_write = 1'b1;
        w.fmt = f;
        w.tx = '0;
        w.gap = 0;
        pending_work.push_back(w);
    endtask

    // driver: holds start until accepted; format writes wait for an empty pipeline
    always @(posedge clk)
    begin
        logic       nx_start;
        logic       nx_we;
        logic [2:0] nx_wdata;
        texel_t     nx_texel;
        nx_start = 1'b0;
        nx_we = 1'b0;
        nx_wdata = cfg_wdata;
        nx_texel = texel;
        if (!rst_n)
        begin
            fmt_shadow = FMT_BGRA8;
            idle_wait = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                fmt_shadow = cfg_wdata;
                format_writes++;
            end
            if (start && !busy)
            begin
                expected_pixels.push_back(predict_pixel(texel, fmt_shadow));
                texels_sent++;
            end
            if (start && busy)
                nx_start = 1'b1;
            else if (pending_work.size() != 0)
            begin
                if (pending_work[0].is_fmt_write)
                begin
                    if (expected_pixels.size() == 0 && !cfg_we)
                    begin
                        nx_we = 1'b1;
                        nx_wdata = pending_work[0].fmt;
                        void'(pending_work.pop_front());
                    end
                end
                else if (idle_wait < pending_work[0].gap)
                    idle_wait++;
                else
                begin
                    nx_start = 1'b1;
                    nx_texel = pending_work[0].tx;
                    void'(pending_work.pop_front());
                    idle_wait = 0;
                end
            end
        end
        start <= nx_start;
        texel <= nx_texel;
        cfg_we <= nx_we;
        cfg_wdata <= nx_wdata;
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result: expected none, actual word %h alpha %b last %b",
                         $time, result.pixel_word, result.has_alpha, result.out_last);
            end
            else
            begin
                want = expected_pixels.pop_front();
                results_seen++;
                if (result.pixel_word !== want.pixel_word)
                begin
                    mismatches++;
                    $display("%0t: pixel_word expected %h actual %h",
                             $time, want.pixel_word, result.pixel_word);
                end
                if (result.has_alpha !== want.has_alpha)
                begin
                    mismatches++;
                    $display("%0t: has_alpha expected %b actual %b",
                             $time, want.has_alpha, result.has_alpha);
                end
                if (result.out_last !== want.out_last)
                begin
                    mismatches++;
                    $display("%0t: out_last expected %b actual %b",
                             $time, want.out_last, result.out_last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_pixels.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        logic [2:0]  fmt_pick;
        int unsigned idle_style;
        int unsigned gap;
        logic [31:0] ch [4];

        // float32 corners: signed zeros, infinities, NaNs, denormals, 1.0 boundary
        add_format(FMT_RGBA_F32);
        add_texel(32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 1'b0, 0);
        add_texel(32'h7FC0_0000, 32'hFFFF_FFFF, 32'h3F80_0000, 32'h3F7F_FFFF, 1'b1, 0);
        add_texel(32'h0000_0001, 32'h7F7F_FFFF, 32'h3F00_0000, 32'hBF80_0000, 1'b0, 2);
        add_texel(32'h3B80_8081, 32'h3C00_0000, 32'h7F80_0001, 32'h007F_FFFF, 1'b1, 0);
        // half corners with junk in the ignored upper bits
        add_format(FMT_RGBA_F16);
        add_texel(32'hFFFF_0000, 32'h0000_8000, 32'hA5A5_7C00, 32'h5A5A_FC00, 1'b1, 0);
        add_texel(32'h0000_7E00, 32'hFFFF_7C01, 32'h1234_3C00, 32'h0000_3BFF, 1'b0, 1);
        add_texel(32'hFFFF_0001, 32'h0000_7BFF, 32'h0000_3800, 32'h0000_BC00, 1'b1, 0);
        add_format(FMT_R_F32);
        add_texel(32'h3F80_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0);
        add_texel(32'h3E80_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 0);
        add_format(FMT_RG_F16);
        add_texel(32'hFFFF_3C00, 32'hFFFF_3400, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 0);
        add_texel(32'h0000_7E00, 32'h0000_7C00, 32'h0000_0000, 32'h0000_0000, 1'b1, 3);
        add_format(FMT_BGRA8);
        add_texel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0);
        add_texel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 0);
        add_format(FMT_BGRX8);
        add_texel(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 0);
        add_texel(32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 0);
        add_format(FMT_RSVD_6);
        add_texel($urandom(), $urandom(), $urandom(), $urandom(), 1'b1, 0);
        add_format(FMT_RSVD_7);
        add_texel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            fmt_pick = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
            add_format(fmt_pick);
            idle_style = $urandom_range(0, 2);
            for (int n = 0; n < TEXELS_PER_PHASE; n++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    if (fmt_pick == FMT_RGBA_F16 || fmt_pick == FMT_RG_F16)
                        ch[c] = pick_f16();
                    else if (fmt_pick == FMT_RGBA_F32 || fmt_pick == FMT_R_F32)
                        ch[c] = pick_f32();
                    else
                        ch[c] = $urandom();
                end
                if (idle_style == 0)
                    gap = 0;
                else if (idle_style == 1)
                    gap = $urandom_range(0, 19);
                else
                    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
                add_texel(ch[0], ch[1], ch[2], ch[3], ($urandom_range(0, 7) == 0), gap);
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_work.size() != 0 || start || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("converted %0d texels across %0d format writes (all eight codes)",
                 texels_sent, format_writes);
        $display("%0d results compared, %0d field mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
